// File: design/cdbt_pkg.sv
// shared constants, codes and types of the chunked download bin tracker
`default_nettype none

package cdbt_pkg;

  localparam int unsigned BINS_PER_CHUNK = 512;
  localparam int unsigned PACKET_BYTES   = 90;
  localparam int unsigned CHUNK_BYTES    = BINS_PER_CHUNK * PACKET_BYTES;

  localparam int unsigned BIN_W     = $clog2(BINS_PER_CHUNK);
  localparam int unsigned NEED_W    = $clog2(BINS_PER_CHUNK + 1);
  localparam int unsigned ROW_BITS  = 8;
  localparam int unsigned ROW_SEL_W = $clog2(ROW_BITS);
  localparam int unsigned ROWS      = BINS_PER_CHUNK / ROW_BITS;
  localparam int unsigned ROW_W     = $clog2(ROWS);

  localparam int unsigned REM_W     = $clog2(PACKET_BYTES + 1);

  // x / 90 == ((x >> 1) * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
  // magic is ceil(2^37 / 45), tied to PACKET_BYTES = 90
  localparam logic [31:0] DIV_MAGIC = 32'd3054198967;
  localparam int unsigned DIV_SHIFT = 37;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_ACCEPTED,
    ST_MISALIGNED,
    ST_BAD_SIZE,
    ST_WRONG_CHUNK,
    ST_BIN_RANGE,
    ST_OUTSIDE,
    ST_LIMIT,
    ST_DUPLICATE
  } status_e;

  typedef enum logic {
    OP_DATA,
    OP_ADVANCE
  } op_e;

  // classified item handed from front to back
  typedef struct packed {
    logic        advance;
    logic [31:0] offset;
    logic [7:0]  byte_count;
    logic [31:0] quot;
    logic        misaligned;
    logic        oversize;
    logic        carry;
    logic [31:0] pkt_end;
  } item_t;

endpackage

`default_nettype wire

// File: design/chunked_download_bin_tracker.sv
// top level of the chunked download bin tracker
`default_nettype none

// Receive-side tracker for a log download sent as fixed 90-byte packets,
// grouped 512 bins to a chunk. Each input beat is either a packet header
// (offset, byte count) or a move to the next chunk, and each one produces
// exactly one result beat: the check status, whether the next bin was
// already present, chunk and log completion, the first missing run of bins,
// and the learned end offset and byte total. The front end takes a beat and
// divides the offset by the packet size with a three-stage reciprocal
// multiplier, takes no new beat until the last one is passed on, and hands
// the classified item through a two-entry queue to the back end. The back
// end checks it against the tracker state, updates the bin bitmap (64 rows
// of 8 bins, one memory port) and scans all 64 rows to find completion and
// the first gap. The back end sets the throughput and takes one item at
// a time; an item takes longer when the end of the log falls inside the
// current chunk, since the number of required bins then goes through its
// own divider. The bitmap needs no clearing pass: a valid flag per row,
// cleared at reset and on each chunk advance, makes an unwritten row read
// as empty. The limit register is written with a single-cycle enable and
// must only change while no item is in flight.
module chunked_download_bin_tracker import cdbt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // limit register
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // input beats
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [31:0] offset_i,
  input  wire logic [7:0]  byte_count_i,
  // result beats
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic             next_bin_present_o,
  output logic             chunk_complete_o,
  output logic             log_complete_o,
  output logic             gap_valid_o,
  output logic [31:0]      gap_offset_o,
  output logic [15:0]      gap_length_o,
  output logic             end_known_o,
  output logic [31:0]      end_position_o,
  output logic [31:0]      total_bytes_o
);

  logic [31:0] max_size_q;
  logic        push;
  item_t       push_item;
  logic        q_full;
  logic        pop;
  item_t       pop_item;
  logic        q_empty;

  // largest allowed packet end offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= '0;
    end else if (cfg_we_i) begin
      max_size_q <= cfg_wdata_i;
    end
  end

  // front: accept and pre-divide
  cdbt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .offset_i     (offset_i),
    .byte_count_i (byte_count_i),
    .push_o       (push),
    .item_o       (push_item),
    .full_i       (q_full)
  );

  // decoupling queue
  cdbt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_item),
    .empty_o (q_empty)
  );

  // back: state update, bitmap and gap scan
  cdbt_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_i             (pop_item),
    .empty_i            (q_empty),
    .pop_o              (pop),
    .max_size_i         (max_size_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .next_bin_present_o (next_bin_present_o),
    .chunk_complete_o   (chunk_complete_o),
    .log_complete_o     (log_complete_o),
    .gap_valid_o        (gap_valid_o),
    .gap_offset_o       (gap_offset_o),
    .gap_length_o       (gap_length_o),
    .end_known_o        (end_known_o),
    .end_position_o     (end_position_o),
    .total_bytes_o      (total_bytes_o)
  );

endmodule

`default_nettype wire

// File: design/cdbt_div.sv
// divider by the packet size: reciprocal multiply, then quotient and remainder with a done flag
`default_nettype none

module cdbt_div import cdbt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [31:0]       dividend_i,
  output logic                   done_o,
  output logic [31:0]            quot_o,
  output logic [REM_W-1:0]       rem_o
);

  logic [2:0]              stage_q;
  logic                    done_q;
  logic [31:0]             num_q;
  logic [62:0]             prod_q;
  logic [62-DIV_SHIFT:0]   quot_q;
  logic [REM_W-1:0]        rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= {stage_q[1:0], start_i};
      done_q  <= stage_q[2];
    end
  end

  // multiply, take the quotient, then the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    prod_q <= 63'(num_q[31:1]) * 63'(DIV_MAGIC);
    quot_q <= prod_q[62:DIV_SHIFT];
    rem_q  <= REM_W'(num_q - 32'(quot_q) * 32'(PACKET_BYTES));
  end

  assign done_o = done_q;
  assign quot_o = 32'(quot_q);
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: design/cdbt_front.sv
// front end: takes input beats, divides the offset and classifies the packet
`default_nettype none

module cdbt_front import cdbt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [31:0] offset_i,
  input  wire logic [7:0]  byte_count_i,
  output logic             push_o,
  output item_t            item_o,
  input  wire logic        full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } fstate_e;

  fstate_e          state_q;
  item_t            item_q;
  logic             accept;
  logic             div_start;
  logic             div_done;
  logic [31:0]      div_quot;
  logic [REM_W-1:0] div_rem;
  logic [32:0]      end_sum;

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign div_start  = accept && (operation_i == OP_DATA);
  assign end_sum    = {1'b0, offset_i} + 33'(byte_count_i);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign item_o     = item_q;

  cdbt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (offset_i),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      item_q  <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            item_q.advance    <= (operation_i == OP_ADVANCE);
            item_q.offset     <= offset_i;
            item_q.byte_count <= byte_count_i;
            item_q.oversize   <= byte_count_i > 8'(PACKET_BYTES);
            item_q.carry      <= end_sum[32];
            item_q.pkt_end    <= end_sum[31:0];
            item_q.quot       <= '0;
            item_q.misaligned <= 1'b0;
            state_q           <= div_start ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          if (div_done) begin
            item_q.quot       <= div_quot;
            item_q.misaligned <= (div_rem != '0);
            state_q           <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/cdbt_queue.sv
// short queue of classified items between front and back
`default_nettype none

module cdbt_queue import cdbt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      data_o,
  output logic       empty_o
);

  item_t             slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/cdbt_back.sv
// back end: applies checks against the tracker state, updates the bitmap, scans for gaps
`default_nettype none

module cdbt_back import cdbt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  item_t            item_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  input  wire logic [31:0] max_size_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic             next_bin_present_o,
  output logic             chunk_complete_o,
  output logic             log_complete_o,
  output logic             gap_valid_o,
  output logic [31:0]      gap_offset_o,
  output logic [15:0]      gap_length_o,
  output logic             end_known_o,
  output logic [31:0]      end_position_o,
  output logic [31:0]      total_bytes_o
);

  typedef enum logic [3:0] {
    B_IDLE,
    B_CHECK,
    B_RDA,
    B_RDB,
    B_NEED,
    B_NDIV,
    B_SCAN,
    B_GAP,
    B_OUT
  } bstate_e;

  // tracker state
  bstate_e              state_q;
  item_t                it_q;
  logic [31:0]          chunk_q;
  logic [31:0]          base_q;
  logic                 end_seen_q;
  logic [31:0]          end_q;
  logic [31:0]          total_q;
  logic [NEED_W-1:0]    tally_q;
  logic [ROWS-1:0]      row_valid_q;

  // per item work registers
  status_e              w_status_q;
  logic                 w_next_q;
  logic [ROW_BITS-1:0]  rowa_q;
  logic [NEED_W-1:0]    need_q;
  logic [NEED_W-1:0]    start_q;
  logic [NEED_W-1:0]    stop_q;
  logic                 found_start_q;
  logic                 found_stop_q;
  logic [ROW_W:0]       issue_q;
  logic                 rd_live_q;
  logic [ROW_W-1:0]     rd_row_q;
  logic [31:0]          goff_q;

  // result registers
  logic                 out_valid_q;
  status_e              status_q;
  logic                 next_bin_q;
  logic                 chunk_done_q;
  logic                 log_done_q;
  logic                 gap_valid_q;
  logic [31:0]          gap_off_q;
  logic [15:0]          gap_len_q;
  logic                 out_end_seen_q;
  logic [31:0]          out_end_q;
  logic [31:0]          out_total_q;

  // bitmap memory, one row of bins per word
  logic [ROW_BITS-1:0]  mem [ROWS];
  logic [ROW_BITS-1:0]  rd_data_q;
  logic                 mem_re;
  logic [ROW_W-1:0]     mem_raddr;
  logic                 mem_we;

  logic [BIN_W-1:0]     bin;
  logic [ROW_W-1:0]     row_a;
  logic [ROW_W-1:0]     row_b;
  logic [ROW_SEL_W-1:0] bit_a;
  logic                 last_pkt;
  status_e              chk_status;
  logic [32:0]          top;
  logic                 end_far;
  logic                 end_low;
  logic [31:0]          need_arg;
  logic                 div_start;
  logic                 div_done;
  logic [31:0]          div_quot;
  logic [REM_W-1:0]     div_rem;
  logic [ROW_BITS-1:0]  rowb_bits;
  logic                 next_hit;
  logic [NEED_W-1:0]    s_start;
  logic [NEED_W-1:0]    s_stop;
  logic                 s_fs;
  logic                 s_fp;
  logic [NEED_W-1:0]    idx;
  logic                 bit_set;
  logic                 out_free;
  logic [31:0]          run_len;
  logic [31:0]          room;
  logic [31:0]          glen;
  logic                 cdone;
  logic                 ldone;
  logic                 gvalid;

  assign bin      = it_q.quot[BIN_W-1:0];
  assign row_a    = bin[BIN_W-1:ROW_SEL_W];
  assign row_b    = row_a + ROW_W'(1);
  assign bit_a    = bin[ROW_SEL_W-1:0];
  assign last_pkt = it_q.byte_count < 8'(PACKET_BYTES);

  // checks in priority order; carry outside before the limit, end checks after it
  always_comb begin
    if (it_q.misaligned) begin
      chk_status = ST_MISALIGNED;
    end else if (it_q.oversize) begin
      chk_status = ST_BAD_SIZE;
    end else if ((it_q.quot >> BIN_W) != chunk_q) begin
      chk_status = ST_WRONG_CHUNK;
    end else if (it_q.carry) begin
      chk_status = ST_OUTSIDE;
    end else if (it_q.pkt_end > max_size_i) begin
      chk_status = ST_LIMIT;
    end else if (end_seen_q && ((last_pkt && it_q.pkt_end != end_q) ||
                 it_q.offset > end_q || it_q.pkt_end > end_q)) begin
      chk_status = ST_OUTSIDE;
    end else if (it_q.byte_count == '0 && end_seen_q) begin
      chk_status = ST_DUPLICATE;
    end else begin
      chk_status = ST_ACCEPTED;
    end
  end

  // required bins: all if end unknown or past this chunk, none if at or below the base
  assign top       = {1'b0, base_q} + 33'(CHUNK_BYTES);
  assign end_far   = !end_seen_q || ({1'b0, end_q} > top);
  assign end_low   = end_q <= base_q;
  assign need_arg  = end_q - base_q + 32'(PACKET_BYTES - 1);
  assign div_start = (state_q == B_NEED) && !end_far && !end_low;

  cdbt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (need_arg),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign rowb_bits = row_valid_q[row_b] ? rd_data_q : '0;
  assign next_hit  = (bit_a == '1) ? ((row_a != '1) && rowb_bits[0])
                                   : rowa_q[bit_a + ROW_SEL_W'(1)];

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = row_a;
    mem_we    = 1'b0;
    case (state_q)
      B_CHECK: mem_re = !it_q.advance && (chk_status == ST_ACCEPTED) &&
                        (it_q.byte_count != '0);
      B_RDA: begin
        mem_re    = 1'b1;
        mem_raddr = row_b;
      end
      B_RDB: mem_we = !rowa_q[bit_a];
      B_SCAN: begin
        mem_re    = issue_q < (ROW_W + 1)'(ROWS);
        mem_raddr = issue_q[ROW_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[row_a] <= rowa_q | (ROW_BITS'(1) << bit_a);
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // first missing run over one row of bins
  always_comb begin
    s_start = start_q;
    s_stop  = stop_q;
    s_fs    = found_start_q;
    s_fp    = found_stop_q;
    idx     = '0;
    bit_set = 1'b0;
    for (int j = 0; j < ROW_BITS; j++) begin
      idx     = NEED_W'({rd_row_q, ROW_SEL_W'(j)});
      bit_set = row_valid_q[rd_row_q] && rd_data_q[j];
      if (!s_fs) begin
        if (idx < need_q && !bit_set) begin
          s_start = idx;
          s_fs    = 1'b1;
        end
      end else if (!s_fp) begin
        if (idx < need_q && bit_set) begin
          s_stop = idx;
          s_fp   = 1'b1;
        end
      end
    end
  end

  // result fields
  assign gvalid  = need_q != '0;
  assign cdone   = start_q == need_q;
  assign ldone   = end_seen_q && (end_q >= base_q) && ({1'b0, end_q} <= top) && cdone;
  assign run_len = 32'(stop_q - start_q) * 32'(PACKET_BYTES);
  assign room    = ~goff_q;
  assign glen    = (run_len < room) ? run_len : room;
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o   = (state_q == B_IDLE) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_IDLE;
      it_q           <= '0;
      chunk_q        <= '0;
      base_q         <= '0;
      end_seen_q     <= 1'b0;
      end_q          <= '0;
      total_q        <= '0;
      tally_q        <= '0;
      row_valid_q    <= '0;
      w_status_q     <= ST_ACCEPTED;
      w_next_q       <= 1'b0;
      rowa_q         <= '0;
      need_q         <= '0;
      start_q        <= '0;
      stop_q         <= '0;
      found_start_q  <= 1'b0;
      found_stop_q   <= 1'b0;
      issue_q        <= '0;
      rd_live_q      <= 1'b0;
      rd_row_q       <= '0;
      goff_q         <= '0;
      out_valid_q    <= 1'b0;
      status_q       <= ST_ACCEPTED;
      next_bin_q     <= 1'b0;
      chunk_done_q   <= 1'b0;
      log_done_q     <= 1'b0;
      gap_valid_q    <= 1'b0;
      gap_off_q      <= '0;
      gap_len_q      <= '0;
      out_end_seen_q <= 1'b0;
      out_end_q      <= '0;
      out_total_q    <= '0;
    end else begin
      // a beat taken in B_OUT is replaced there by the next one
      if (out_valid_q && out_ready_i && (state_q != B_OUT)) begin
        out_valid_q <= 1'b0;
      end
      rd_live_q <= (state_q == B_SCAN) && mem_re;
      rd_row_q  <= issue_q[ROW_W-1:0];
      case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            it_q    <= item_i;
            state_q <= B_CHECK;
          end
        end
        B_CHECK: begin
          w_next_q   <= 1'b0;
          w_status_q <= it_q.advance ? ST_ACCEPTED : chk_status;
          if (it_q.advance) begin
            chunk_q     <= chunk_q + 32'd1;
            base_q      <= base_q + 32'(CHUNK_BYTES);
            tally_q     <= '0;
            row_valid_q <= '0;
            state_q     <= B_NEED;
          end else if (chk_status != ST_ACCEPTED) begin
            state_q    <= B_NEED;
          end else if (it_q.byte_count == '0) begin
            // empty packet fixes the end of the log
            end_seen_q <= 1'b1;
            end_q      <= it_q.offset;
            state_q    <= B_NEED;
          end else begin
            state_q <= B_RDA;
          end
        end
        B_RDA: begin
          rowa_q  <= row_valid_q[row_a] ? rd_data_q : '0;
          state_q <= B_RDB;
        end
        B_RDB: begin
          if (rowa_q[bit_a]) begin
            w_status_q <= ST_DUPLICATE;
          end else begin
            row_valid_q[row_a] <= 1'b1;
            tally_q            <= tally_q + NEED_W'(1);
            total_q            <= total_q + 32'(it_q.byte_count);
            w_next_q           <= next_hit;
            if (last_pkt) begin
              end_seen_q <= 1'b1;
              end_q      <= it_q.pkt_end;
            end
          end
          state_q <= B_NEED;
        end
        B_NEED: begin
          found_start_q <= 1'b0;
          found_stop_q  <= 1'b0;
          issue_q       <= '0;
          if (end_far) begin
            need_q  <= NEED_W'(BINS_PER_CHUNK);
            start_q <= NEED_W'(BINS_PER_CHUNK);
            stop_q  <= NEED_W'(BINS_PER_CHUNK);
            state_q <= B_SCAN;
          end else if (end_low) begin
            need_q  <= '0;
            start_q <= '0;
            stop_q  <= '0;
            state_q <= B_SCAN;
          end else begin
            state_q <= B_NDIV;
          end
        end
        B_NDIV: begin
          if (div_done) begin
            need_q  <= div_quot[NEED_W-1:0];
            start_q <= div_quot[NEED_W-1:0];
            stop_q  <= div_quot[NEED_W-1:0];
            state_q <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (mem_re) begin
            issue_q <= issue_q + (ROW_W + 1)'(1);
          end
          if (rd_live_q) begin
            start_q       <= s_start;
            stop_q        <= s_stop;
            found_start_q <= s_fs;
            found_stop_q  <= s_fp;
            if (rd_row_q == ROW_W'(ROWS - 1)) begin
              state_q <= B_GAP;
            end
          end
        end
        B_GAP: begin
          goff_q  <= base_q + 32'(32'(start_q) * 32'(PACKET_BYTES));
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            status_q       <= w_status_q;
            next_bin_q     <= w_next_q;
            chunk_done_q   <= cdone;
            log_done_q     <= ldone;
            gap_valid_q    <= gvalid;
            gap_off_q      <= gvalid ? goff_q : '0;
            gap_len_q      <= gvalid ? glen[15:0] : '0;
            out_end_seen_q <= end_seen_q;
            out_end_q      <= end_q;
            out_total_q    <= total_q;
            state_q        <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign next_bin_present_o = next_bin_q;
  assign chunk_complete_o   = chunk_done_q;
  assign log_complete_o     = log_done_q;
  assign gap_valid_o        = gap_valid_q;
  assign gap_offset_o       = gap_off_q;
  assign gap_length_o       = gap_len_q;
  assign end_known_o        = out_end_seen_q;
  assign end_position_o     = out_end_q;
  assign total_bytes_o      = out_total_q;

`ifndef SYNTHESIS
  ap_tally_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q <= NEED_W'(BINS_PER_CHUNK))
    else $error("bin tally beyond chunk size");

  ap_next_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && next_bin_q |-> status_q == ST_ACCEPTED)
    else $error("next bin flag on a rejected beat");

  ap_log_needs_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && log_done_q |-> chunk_done_q && out_end_seen_q)
    else $error("log complete without chunk complete and known end");

  ap_no_gap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !gap_valid_q |-> gap_len_q == '0 && gap_off_q == '0)
    else $error("gap fields set with no required bins");

  ap_done_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && chunk_done_q && gap_valid_q |-> gap_len_q == '0)
    else $error("missing run reported on a complete chunk");
`endif

endmodule

`default_nettype wire
